### rtl/core/bhsp_pkg.sv
// Package for the bitmap header shape parser: types, constants and the palette plan function.
`default_nettype none
package bhsp_pkg;

  // File layout offsets and header sizes
  localparam logic [31:0] OFS_HDR_LEN    = 32'd14;
  localparam logic [31:0] MIN_LEN        = 32'd18;
  localparam logic [31:0] CORE_MIN_LEN   = 32'd26;
  localparam logic [31:0] INFO_MIN_LEN   = 32'd50;
  localparam logic [31:0] CORE_HDR_LEN   = 32'd12;
  localparam logic [31:0] INFO_HDR_LEN   = 32'd40;
  localparam logic [32:0] CORE_PAL_START = 33'd26;
  localparam logic [31:0] SAT_OFFSET     = 32'hFFFF_FFFF;
  localparam logic [15:0] MAX_PAL_BPP    = 16'd8;

  // Compression kinds
  localparam logic [31:0] COMP_RGB       = 32'd0;
  localparam logic [31:0] COMP_RLE8      = 32'd1;
  localparam logic [31:0] COMP_BITFIELDS = 32'd3;

  // Bits per pixel of interest
  localparam logic [15:0] BPP_16 = 16'd16;
  localparam logic [15:0] BPP_24 = 16'd24;
  localparam logic [15:0] BPP_32 = 16'd32;

  // Channel counts
  localparam logic [2:0] CH_NONE = 3'd0;
  localparam logic [2:0] CH_GREY = 3'd1;
  localparam logic [2:0] CH_RGB  = 3'd3;
  localparam logic [2:0] CH_RGBA = 3'd4;

  // Status codes
  localparam logic [1:0] ST_OK        = 2'd0;
  localparam logic [1:0] ST_SHORT     = 2'd1;
  localparam logic [1:0] ST_BAD_HDR   = 2'd2;
  localparam logic [1:0] ST_PAL_TRUNC = 2'd3;

  typedef struct packed {
    logic [7:0] data_byte;
    logic       last_byte;
  } in_item_t;

  typedef struct packed {
    logic [31:0]        image_height;
    logic signed [31:0] image_width;
    logic [2:0]         channel_count;
    logic [1:0]         parse_status;
  } out_item_t;

  typedef struct packed {
    logic [31:0] header_length;
    logic [31:0] raw_width;
    logic [31:0] raw_height;
    logic [15:0] bits_per_pixel;
    logic [31:0] compression_kind;
    logic [31:0] palette_colours;
  } hdr_t;

  typedef struct packed {
    logic        ok;     // palette scan applies
    logic        esize4; // 4-byte entries, else 3-byte
    logic [32:0] start;  // first palette byte offset
    logic [33:0] stop;   // one past the last palette byte
  } plan_t;

  typedef struct packed {
    logic step;  // one byte processed this cycle
    logic clear; // byte was the last of the file: return to reset
  } ctl_t;

  function automatic plan_t pal_plan(input hdr_t h);
    plan_t       p;
    logic [8:0]  full;
    logic [31:0] n;
    logic [8:0]  count;
    logic [10:0] span;
    p     = '0;
    full  = 9'd1 << h.bits_per_pixel[3:0];
    n     = (h.palette_colours == 32'd0) ? {23'd0, full} : h.palette_colours;
    count = 9'd0;
    span  = 11'd0;
    if (h.bits_per_pixel <= MAX_PAL_BPP) begin
      if (h.header_length == CORE_HDR_LEN) begin
        count    = full;
        span     = {1'b0, count, 1'b0} + {2'd0, count};
        p.ok     = 1'b1;
        p.esize4 = 1'b0;
        p.start  = CORE_PAL_START;
        p.stop   = {1'b0, p.start} + {23'd0, span};
      end else if (h.header_length >= INFO_HDR_LEN && h.compression_kind <= COMP_RLE8
                   && n <= {23'd0, full}) begin
        count    = n[8:0];
        span     = {count, 2'b00};
        p.ok     = 1'b1;
        p.esize4 = 1'b1;
        p.start  = {1'b0, h.header_length} + {1'b0, OFS_HDR_LEN};
        p.stop   = {1'b0, p.start} + {23'd0, span};
      end
    end
    return p;
  endfunction

endpackage
`default_nettype wire

### rtl/core/bhsp_hdr_capture.sv
// Byte offset counter and little-endian capture of the header fields.
`default_nettype none
module bhsp_hdr_capture
  import bhsp_pkg::*;
(
  input  wire logic        clk,
  input  wire logic        rst_n,
  input  wire ctl_t        ctl,
  input  wire logic [7:0]  data_byte,
  output logic      [31:0] offset,
  output hdr_t             hdr_cur,
  output hdr_t             hdr_nxt,
  output logic      [31:0] len_nxt
);

  logic [31:0] offset_r;
  logic [31:0] offset_nxt;
  hdr_t        hdr_r;
  logic [1:0]  k2;

  function automatic logic [31:0] put32(input logic [31:0] f, input logic [1:0] k,
                                        input logic [7:0] b);
    logic [31:0] r;
    r = f;
    r[8*k +: 8] = b;
    return r;
  endfunction

  function automatic logic [15:0] put16(input logic [15:0] f, input logic k,
                                        input logic [7:0] b);
    logic [15:0] r;
    r = f;
    r[8*k +: 8] = b;
    return r;
  endfunction

  // Fields starting at offsets 14, 18, 22, 30 and 46 all have low bits 2'b10
  assign k2 = offset_r[1:0] - 2'd2;

  always_comb begin
    hdr_nxt    = hdr_r;
    offset_nxt = offset_r;
    if (ctl.step && offset_r != SAT_OFFSET) begin
      offset_nxt = offset_r + 32'd1;
      if (offset_r >= 32'd14 && offset_r <= 32'd17) begin
        hdr_nxt.header_length = put32(hdr_r.header_length, k2, data_byte);
      end else if (offset_r >= MIN_LEN && hdr_r.header_length == CORE_HDR_LEN) begin
        if (offset_r <= 32'd19) begin
          hdr_nxt.raw_width = put32(hdr_r.raw_width, k2, data_byte);
        end else if (offset_r <= 32'd21) begin
          hdr_nxt.raw_height = put32(hdr_r.raw_height, offset_r[1:0], data_byte);
        end else if (offset_r >= 32'd24 && offset_r <= 32'd25) begin
          hdr_nxt.bits_per_pixel = put16(hdr_r.bits_per_pixel, offset_r[0], data_byte);
        end
      end else if (offset_r >= MIN_LEN) begin
        if (offset_r <= 32'd21) begin
          hdr_nxt.raw_width = put32(hdr_r.raw_width, k2, data_byte);
        end else if (offset_r <= 32'd25) begin
          hdr_nxt.raw_height = put32(hdr_r.raw_height, k2, data_byte);
        end else if (offset_r >= 32'd28 && offset_r <= 32'd29) begin
          hdr_nxt.bits_per_pixel = put16(hdr_r.bits_per_pixel, offset_r[0], data_byte);
        end else if (offset_r >= 32'd30 && offset_r <= 32'd33) begin
          hdr_nxt.compression_kind = put32(hdr_r.compression_kind, k2, data_byte);
        end else if (offset_r >= 32'd46 && offset_r <= 32'd49) begin
          hdr_nxt.palette_colours = put32(hdr_r.palette_colours, k2, data_byte);
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n || ctl.clear) begin
      offset_r <= '0;
      hdr_r    <= '0;
    end else begin
      offset_r <= offset_nxt;
      hdr_r    <= hdr_nxt;
    end
  end

  assign offset  = offset_r;
  assign hdr_cur = hdr_r;
  assign len_nxt = offset_nxt;

  // Drop all per-file state once the last byte is processed
  a_clear_zero: assert property (@(posedge clk) disable iff (!rst_n)
    ctl.clear |=> (offset_r == 32'd0 && hdr_r.header_length == 32'd0))
    else $error("offset not cleared after last byte");

  // Hold the offset once it saturates
  a_sat_hold: assert property (@(posedge clk) disable iff (!rst_n)
    (offset_r == SAT_OFFSET && !ctl.clear) |=> offset_r == SAT_OFFSET)
    else $error("saturated offset moved");

endmodule
`default_nettype wire

### rtl/core/bhsp_pal_scan.sv
// Palette scan: tracks entry phase and flags any entry whose blue, green and red are not all equal.
`default_nettype none
module bhsp_pal_scan
  import bhsp_pkg::*;
(
  input  wire logic        clk,
  input  wire logic        rst_n,
  input  wire ctl_t        ctl,
  input  wire logic [7:0]  data_byte,
  input  wire logic [31:0] offset,
  input  wire hdr_t        hdr_cur,
  output logic             has_colour_nxt
);

  plan_t      plan;
  logic       in_pal;
  logic [1:0] phase_r;
  logic [1:0] phase_nxt;
  logic [7:0] blue_r;
  logic [7:0] blue_nxt;
  logic [7:0] green_r;
  logic [7:0] green_nxt;
  logic       has_r;
  logic [1:0] phase_last;

  // Header fields are complete before the palette starts, so the current
  // header gives the same plan as the one after this byte's capture.
  assign plan       = pal_plan(hdr_cur);
  assign phase_last = plan.esize4 ? 2'd3 : 2'd2;
  assign in_pal     = ctl.step && offset != SAT_OFFSET && plan.ok
                      && {1'b0, offset} >= plan.start
                      && {2'b00, offset} < plan.stop;

  always_comb begin
    phase_nxt      = phase_r;
    blue_nxt       = blue_r;
    green_nxt      = green_r;
    has_colour_nxt = has_r;
    if (in_pal) begin
      phase_nxt = (phase_r == phase_last) ? 2'd0 : phase_r + 2'd1;
      unique case (phase_r)
        2'd0: blue_nxt = data_byte;
        2'd1: green_nxt = data_byte;
        2'd2: begin
          if (blue_r != green_r || blue_r != data_byte) begin
            has_colour_nxt = 1'b1;
          end
        end
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n || ctl.clear) begin
      phase_r <= '0;
      blue_r  <= '0;
      green_r <= '0;
      has_r   <= 1'b0;
    end else begin
      phase_r <= phase_nxt;
      blue_r  <= blue_nxt;
      green_r <= green_nxt;
      has_r   <= has_colour_nxt;
    end
  end

endmodule
`default_nettype wire

### rtl/core/bhsp_result.sv
// Result evaluation at end of file and the output register.
`default_nettype none
module bhsp_result
  import bhsp_pkg::*;
(
  input  wire logic        clk,
  input  wire logic        rst_n,
  input  wire ctl_t        ctl,
  input  wire hdr_t        hdr_nxt,
  input  wire logic [31:0] len_nxt,
  input  wire logic        has_colour,
  output logic             slot_free,
  output logic             out_valid,
  input  wire logic        out_ready,
  output out_item_t        out_data
);

  plan_t     plan;
  logic      core;
  logic      info;
  out_item_t res;
  logic      out_valid_r;
  logic      out_valid_nxt;
  out_item_t out_data_r;

  assign plan = pal_plan(hdr_nxt);
  assign core = hdr_nxt.header_length == CORE_HDR_LEN && len_nxt >= CORE_MIN_LEN;
  assign info = hdr_nxt.header_length >= INFO_HDR_LEN && len_nxt >= INFO_MIN_LEN;

  always_comb begin
    res = '0;
    if (len_nxt < MIN_LEN) begin
      res.parse_status = ST_SHORT;
    end else if (!core && !info) begin
      res.parse_status = ST_BAD_HDR;
    end else begin
      res.parse_status = ST_OK;
      res.image_width  = hdr_nxt.raw_width;
      if (core || !hdr_nxt.raw_height[31]) begin
        res.image_height = hdr_nxt.raw_height;
      end else begin
        res.image_height = ~hdr_nxt.raw_height + 32'd1;
      end
      if (plan.ok) begin
        res.channel_count = has_colour ? CH_RGB : CH_GREY;
        if ({2'b00, len_nxt} < plan.stop) begin
          res.parse_status = ST_PAL_TRUNC;
        end
      end else if (core || hdr_nxt.compression_kind <= COMP_RLE8) begin
        if (hdr_nxt.bits_per_pixel == BPP_24) begin
          res.channel_count = CH_RGB;
        end else if (hdr_nxt.bits_per_pixel == BPP_32) begin
          res.channel_count = CH_RGBA;
        end
      end else if (hdr_nxt.compression_kind == COMP_BITFIELDS) begin
        if (hdr_nxt.bits_per_pixel == BPP_16) begin
          res.channel_count = CH_RGB;
        end else if (hdr_nxt.bits_per_pixel == BPP_32) begin
          res.channel_count = CH_RGBA;
        end
      end
    end
  end

  assign slot_free = !out_valid_r || out_ready;

  always_comb begin
    out_valid_nxt = out_valid_r && !out_ready;
    if (ctl.clear) begin
      out_valid_nxt = 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else begin
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (ctl.clear) begin
      out_data_r <= res;
    end
  end

  assign out_valid = out_valid_r;
  assign out_data  = out_data_r;

  // A finished file must only be loaded into a free output slot
  a_load_free: assert property (@(posedge clk) disable iff (!rst_n)
    ctl.clear |-> slot_free)
    else $error("result loaded over a pending transfer");

endmodule
`default_nettype wire

### rtl/core/bmp_header_shape_parser.sv
// Top level of the bitmap header shape parser: input register and stage wiring.
`default_nettype none
// Streams a bitmap file one byte per transfer (last_byte marks the end) and
// returns one result per file: absolute height, signed width, channel count
// and a status (ok, short file, unrecognized header, truncated palette).
// Both core (12-byte) and info (40 bytes or more) headers are understood;
// for 8 bits per pixel or fewer the palette, where the palette plan applies, is checked for non-grey entries.
// Throughput is one byte per cycle, save for the stall below: each byte is
// held in the input register and then folded into the header and palette
// registers as it leaves it, and the output register loads at that same edge,
// so a file's result is registered as its last byte leaves the input register.
// The only stall comes from the output register: when the last byte of a
// file reaches processing while the previous result is still pending, the
// input register holds until that result transfers. After the last byte all
// per-file state returns to reset, so the next file may follow at once.
// Offsets past 0xFFFFFFFE are not examined and the file length saturates.
module bmp_header_shape_parser
  import bhsp_pkg::*;
(
  input  wire logic      clk,
  input  wire logic      rst_n,
  input  wire logic      in_valid,
  output logic           in_ready,
  input  wire in_item_t  in_data,
  output logic           out_valid,
  input  wire logic      out_ready,
  output out_item_t      out_data
);

  logic        s1_valid_r;
  logic        s1_valid_nxt;
  in_item_t    s1_item_r;
  logic        s1_go;
  logic        slot_free;
  ctl_t        ctl;
  logic [31:0] offset;
  hdr_t        hdr_cur;
  hdr_t        hdr_nxt;
  logic [31:0] len_nxt;
  logic        has_colour_nxt;

  // Advance the held byte unless it ends a file and the output slot is busy
  assign s1_go     = s1_valid_r && (!s1_item_r.last_byte || slot_free);
  assign in_ready  = !s1_valid_r || s1_go;
  assign ctl.step  = s1_go;
  assign ctl.clear = s1_go && s1_item_r.last_byte;

  always_comb begin
    s1_valid_nxt = s1_valid_r && !s1_go;
    if (in_valid && in_ready) begin
      s1_valid_nxt = 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_valid_r <= 1'b0;
    end else begin
      s1_valid_r <= s1_valid_nxt;
    end
  end

  // Capture payload on every input transfer
  always_ff @(posedge clk) begin
    if (in_valid && in_ready) begin
      s1_item_r <= in_data;
    end
  end

  bhsp_hdr_capture u_hdr (
    .clk       (clk),
    .rst_n     (rst_n),
    .ctl       (ctl),
    .data_byte (s1_item_r.data_byte),
    .offset    (offset),
    .hdr_cur   (hdr_cur),
    .hdr_nxt   (hdr_nxt),
    .len_nxt   (len_nxt)
  );

  bhsp_pal_scan u_pal (
    .clk            (clk),
    .rst_n          (rst_n),
    .ctl            (ctl),
    .data_byte      (s1_item_r.data_byte),
    .offset         (offset),
    .hdr_cur        (hdr_cur),
    .has_colour_nxt (has_colour_nxt)
  );

  bhsp_result u_res (
    .clk        (clk),
    .rst_n      (rst_n),
    .ctl        (ctl),
    .hdr_nxt    (hdr_nxt),
    .len_nxt    (len_nxt),
    .has_colour (has_colour_nxt),
    .slot_free  (slot_free),
    .out_valid  (out_valid),
    .out_ready  (out_ready),
    .out_data   (out_data)
  );

  // A held last byte blocked by a busy output must still be there next cycle
  a_hold_last: assert property (@(posedge clk) disable iff (!rst_n)
    (s1_valid_r && s1_item_r.last_byte && !slot_free)
      |=> (s1_valid_r && s1_item_r.last_byte))
    else $error("blocked last byte was lost");

endmodule
`default_nettype wire
